[design/mini_cpu_execute_unit_core_assert.svh]
// Assertion helpers shared by the execute unit RTL.
`ifndef MINI_CPU_EXECUTE_UNIT_CORE_ASSERT_SVH
`define MINI_CPU_EXECUTE_UNIT_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MCPU_EU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MCPU_EU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mcpu_eu_pkg.sv]
`default_nettype none

package mcpu_eu_pkg;

    localparam int REG_COUNT = 4;
    localparam int MEM_BYTES = 256;
    localparam int RF_AW     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int FUNC_W    = 4;
    localparam int DATA_W    = 8;

    typedef enum logic [FUNC_W-1:0] {
        FN_LDI    = 4'd0,
        FN_LDM    = 4'd1,
        FN_ST     = 4'd2,
        FN_ADD    = 4'd3,
        FN_SUB    = 4'd4,
        FN_PRINT  = 4'd5,
        FN_JMP    = 4'd6,
        FN_JZ     = 4'd7,
        FN_JNZ    = 4'd8,
        FN_STOP   = 4'd9,
        FN_HOSTWR = 4'd10
    } t_func;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_BAD_REG  = 2'd1,
        ERR_BAD_FUNC = 2'd2
    } t_err;

    // register file write port
    typedef struct packed {
        logic              en;
        logic [RF_AW-1:0]  idx;
        logic [DATA_W-1:0] data;
    } t_rf_wr;

    // data memory write port
    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] idx;
        logic [DATA_W-1:0] data;
    } t_dm_wr;

    // byte address -> memory index, folded by repeated subtraction at elaboration
    typedef logic [MEM_AW-1:0] t_idx_tab [256];

    function automatic t_idx_tab build_idx_tab();
        t_idx_tab tab;
        for (int i = 0; i < 256; i++) begin
            if (i >= MEM_BYTES) begin
                tab[i] = tab[i-MEM_BYTES];
            end else begin
                tab[i] = MEM_AW'(i);
            end
        end
        return tab;
    endfunction

    localparam t_idx_tab ADDR_IDX = build_idx_tab();

    function automatic logic [MEM_AW-1:0] mem_index(input logic [DATA_W-1:0] addr);
        return ADDR_IDX[addr];
    endfunction

    function automatic logic reg_bad(input logic [DATA_W-1:0] r);
        return {1'b0, r} >= (DATA_W+1)'(REG_COUNT);
    endfunction

endpackage

`default_nettype wire

[design/mcpu_eu_if.sv]
`default_nettype none

interface mcpu_eu_in_if;
    import mcpu_eu_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;

    modport source (output valid, output func, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input func, input operand_a, input operand_b,
                    output ready);
endinterface

interface mcpu_eu_out_if;
    import mcpu_eu_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] next_pc;
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              halted;
    logic [1:0]        error_code;

    modport source (output valid, output next_pc, output print_valid,
                    output print_value, output halted, output error_code,
                    input ready);
    modport sink   (input valid, input next_pc, input print_valid,
                    input print_value, input halted, input error_code,
                    output ready);
endinterface

`default_nettype wire

[design/mini_cpu_execute_unit_core.sv]
// Execute unit of a small 8-bit register machine. Each input item is one
// decoded instruction (func, operand_a, operand_b); each one yields exactly one
// result item with the program counter, print value, halt flag and error code
// after it. The unit sustains one item per clock while the output register is
// free or being drained: an item is accepted, its register file and data
// memory reads are issued on that edge, it executes in the next cycle and
// commits on the following edge unless a full output register is not drained;
// the commit also loads the output register. Rate is set by the
// read-modify-write of the register file and data memory; a one-entry write
// record on each memory forwards the write of the item just committed to the
// item right behind it. Register file and data memory read as zero after reset
// through per-entry valid bits, so there is no clearing pass and the unit
// takes items from the first cycle after reset. Once a stop executes,
// everything but host writes is ignored until reset.
`default_nettype none

`include "mini_cpu_execute_unit_core_assert.svh"

module mini_cpu_execute_unit_core
    import mcpu_eu_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    mcpu_eu_in_if.sink  i_in,
    mcpu_eu_out_if.source o_out
);

    // handshake
    logic in_fire;
    logic s1_commit;

    // execute stage
    logic              r_s1_vld;
    logic [FUNC_W-1:0] r_s1_func;
    logic [DATA_W-1:0] r_s1_a;
    logic [DATA_W-1:0] r_s1_b;

    // architectural state kept in flops
    logic [DATA_W-1:0] r_pc;
    logic              r_halt;

    // memory ports
    logic [DATA_W-1:0] rf_rdata_a;
    logic [DATA_W-1:0] rf_rdata_b;
    logic [DATA_W-1:0] dm_rdata;
    t_rf_wr            rf_wr;
    t_dm_wr            dm_wr;
    t_rf_wr            r_rf_fwd;    // last committed register write
    t_dm_wr            r_dm_fwd;    // last committed memory write

    // forwarded operands
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    logic [DATA_W-1:0] mem_val;

    // execute results
    t_func             fn;
    t_err              n_err;
    logic              n_pv;
    logic [DATA_W-1:0] n_pval;
    logic [DATA_W-1:0] n_pc;
    logic              n_halt;
    logic              advance;
    logic              jumped;
    logic              need_a;
    logic              need_b;

    // output register
    logic              r_o_vld;
    logic [DATA_W-1:0] r_o_pc;
    logic              r_o_pv;
    logic [DATA_W-1:0] r_o_pval;
    logic              r_o_halt;
    t_err              r_o_err;

    // The execute stage moves on whenever the output register is free or
    // being drained; a waiting result blocks the next accept only while an item sits in the stage.
    assign s1_commit  = r_s1_vld && (!r_o_vld || o_out.ready);
    assign i_in.ready = !r_s1_vld || s1_commit;
    assign in_fire    = i_in.valid && i_in.ready;

    // reads are launched only on accept, so stalled read data stays put
    mcpu_eu_rf u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ren     (in_fire),
        .i_raddr_a (i_in.operand_a[RF_AW-1:0]),
        .i_raddr_b (i_in.operand_b[RF_AW-1:0]),
        .i_wr      (rf_wr),
        .o_rdata_a (rf_rdata_a),
        .o_rdata_b (rf_rdata_b)
    );

    mcpu_eu_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ren   (in_fire),
        .i_raddr (mem_index(i_in.operand_b)),
        .i_wr    (dm_wr),
        .o_rdata (dm_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_fire) begin
            r_s1_vld <= 1'b1;
        end else if (s1_commit) begin
            r_s1_vld <= 1'b0;
        end
        if (in_fire) begin
            r_s1_func <= i_in.func;
            r_s1_a    <= i_in.operand_a;
            r_s1_b    <= i_in.operand_b;
        end
    end

    // The read of an item and the commit of the item ahead of it can share an
    // edge; the memory returns old data then, so the write record patches it.
    // Older writes are already in the arrays.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_fwd <= '0;
            r_dm_fwd <= '0;
        end else begin
            if (rf_wr.en) begin
                r_rf_fwd <= rf_wr;
            end
            if (dm_wr.en) begin
                r_dm_fwd <= dm_wr;
            end
        end
    end

    assign op_a = (r_rf_fwd.en && r_rf_fwd.idx == r_s1_a[RF_AW-1:0]) ?
                  r_rf_fwd.data : rf_rdata_a;
    assign op_b = (r_rf_fwd.en && r_rf_fwd.idx == r_s1_b[RF_AW-1:0]) ?
                  r_rf_fwd.data : rf_rdata_b;
    assign mem_val = (r_dm_fwd.en && r_dm_fwd.idx == mem_index(r_s1_b)) ?
                     r_dm_fwd.data : dm_rdata;

    assign fn = t_func'(r_s1_func);

    always_comb begin
        n_err   = ERR_OK;
        n_pv    = 1'b0;
        n_pval  = '0;
        n_halt  = r_halt;
        advance = 1'b0;
        jumped  = 1'b0;
        rf_wr   = '0;
        dm_wr   = '0;
        need_a  = r_s1_func inside {FN_LDI, FN_LDM, FN_ADD, FN_SUB, FN_PRINT,
                                    FN_JZ, FN_JNZ};
        need_b  = r_s1_func inside {FN_ST, FN_ADD, FN_SUB};

        if (r_s1_func == FN_HOSTWR) begin
            // host preload works even while halted, PC untouched
            dm_wr.en   = 1'b1;
            dm_wr.idx  = mem_index(r_s1_a);
            dm_wr.data = r_s1_b;
        end else if (r_halt) begin
            // halted: no effect
        end else if (r_s1_func > FN_HOSTWR) begin
            n_err = ERR_BAD_FUNC;
        end else if ((need_a && reg_bad(r_s1_a)) || (need_b && reg_bad(r_s1_b))) begin
            n_err = ERR_BAD_REG;
        end else begin
            advance = 1'b1;
            case (fn)
                FN_LDI: begin
                    rf_wr.en   = 1'b1;
                    rf_wr.idx  = r_s1_a[RF_AW-1:0];
                    rf_wr.data = r_s1_b;
                end
                FN_LDM: begin
                    rf_wr.en   = 1'b1;
                    rf_wr.idx  = r_s1_a[RF_AW-1:0];
                    rf_wr.data = mem_val;
                end
                FN_ST: begin
                    dm_wr.en   = 1'b1;
                    dm_wr.idx  = mem_index(r_s1_a);
                    dm_wr.data = op_b;
                end
                FN_ADD: begin
                    rf_wr.en   = 1'b1;
                    rf_wr.idx  = r_s1_a[RF_AW-1:0];
                    rf_wr.data = op_a + op_b;
                end
                FN_SUB: begin
                    rf_wr.en   = 1'b1;
                    rf_wr.idx  = r_s1_a[RF_AW-1:0];
                    rf_wr.data = op_a - op_b;
                end
                FN_PRINT: begin
                    n_pv   = 1'b1;
                    n_pval = op_a;
                end
                FN_JMP: begin
                    jumped = 1'b1;
                end
                FN_JZ: begin
                    jumped = (op_a == '0);
                end
                FN_JNZ: begin
                    jumped = (op_a != '0);
                end
                FN_STOP: begin
                    n_halt  = 1'b1;
                    advance = 1'b0;
                end
                default: begin
                    advance = 1'b0;
                end
            endcase
        end

        n_pc = advance ? (jumped ? r_s1_b : r_pc + DATA_W'(3)) : r_pc;

        // state changes only when the item actually leaves the stage
        rf_wr.en = rf_wr.en && s1_commit;
        dm_wr.en = dm_wr.en && s1_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_halt <= 1'b0;
        end else if (s1_commit) begin
            r_pc   <= n_pc;
            r_halt <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s1_commit) begin
            r_o_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
        if (s1_commit) begin
            r_o_pc   <= n_pc;
            r_o_pv   <= n_pv;
            r_o_pval <= n_pval;
            r_o_halt <= n_halt;
            r_o_err  <= n_err;
        end
    end

    assign o_out.valid       = r_o_vld;
    assign o_out.next_pc     = r_o_pc;
    assign o_out.print_valid = r_o_pv;
    assign o_out.print_value = r_o_pval;
    assign o_out.halted      = r_o_halt;
    assign o_out.error_code  = r_o_err;

    `MCPU_EU_ASSERT_NEXT(a_halt_sticky, r_halt, r_halt, "halt flag dropped without reset")
    `MCPU_EU_ASSERT_SAME(a_err_no_write, s1_commit && n_err != ERR_OK, !rf_wr.en && !dm_wr.en, "faulted item wrote state")
    `MCPU_EU_ASSERT_SAME(a_halt_no_reg_write, r_halt, !rf_wr.en, "register write while halted")
    `MCPU_EU_ASSERT_NEXT(a_pc_on_commit, !s1_commit, $stable(r_pc), "program counter moved without commit")

endmodule

`default_nettype wire

[design/mcpu_eu_rf.sv]
`default_nettype none

// Register file: two registered read ports, one write port.
// Per-entry valid bits give the zero reset value.
module mcpu_eu_rf
    import mcpu_eu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_ren,
    input  wire logic [RF_AW-1:0]  i_raddr_a,
    input  wire logic [RF_AW-1:0]  i_raddr_b,
    input  wire t_rf_wr            i_wr,
    output      logic [DATA_W-1:0] o_rdata_a,
    output      logic [DATA_W-1:0] o_rdata_b
);

    logic [DATA_W-1:0]    r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    logic [DATA_W-1:0]    r_rdata_a;
    logic [DATA_W-1:0]    r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_ren) begin
            r_rdata_a <= r_vld[i_raddr_a] ? r_mem[i_raddr_a] : '0;
            r_rdata_b <= r_vld[i_raddr_b] ? r_mem[i_raddr_b] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.idx] <= 1'b1;
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

[design/mcpu_eu_dmem.sv]
`default_nettype none

// Data memory: one registered read port, one write port.
// Per-byte valid bits give the zero reset value without a clearing pass.
module mcpu_eu_dmem
    import mcpu_eu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_ren,
    input  wire logic [MEM_AW-1:0] i_raddr,
    input  wire t_dm_wr            i_wr,
    output      logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0]    r_mem [MEM_BYTES];
    logic [MEM_BYTES-1:0] r_vld;
    logic [DATA_W-1:0]    r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_ren) begin
            r_rdata <= r_vld[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.idx] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 100ps

// Execute unit testbench: a directed table, then constrained-by-hand random
// instruction streams, then a halted tail. Every result is checked against a
// cycle-free model of the register machine kept alongside the stimulus, or against the row's own result for typed rows.
module testbench;
    import mcpu_eu_pkg::*;

    localparam int WATCHDOG_CYCLES = 200000;
    localparam int RANDOM_ITEMS    = 535;
    localparam int HALTED_ITEMS    = 40;
    localparam int MAX_WAIT        = 12;
    localparam int DRAIN_CYCLES    = 4 * MAX_WAIT;    // outlasts a sink stall

    // function codes the package leaves undefined
    localparam logic [FUNC_W-1:0] FN_UNDEF_LO = 4'd11;
    localparam logic [FUNC_W-1:0] FN_UNDEF_HI = 4'd15;

    typedef struct packed {
        logic [DATA_W-1:0] next_pc;
        logic              print_valid;
        logic [DATA_W-1:0] print_value;
        logic              halted;
        t_err              error_code;
    } t_result;

    localparam t_result NO_EXP = '{8'd0, 1'b0, 8'd0, 1'b0, ERR_OK};

    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        bit                typed;   // take want as is instead of the model
        t_result           want;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #4 i_clk = ~i_clk;

    mcpu_eu_in_if  in_ch ();
    mcpu_eu_out_if out_ch ();

    mini_cpu_execute_unit_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // ---------------------------------------------------------------------
    // Machine state as seen by the model
    // ---------------------------------------------------------------------
    logic [DATA_W-1:0] gpr  [REG_COUNT] = '{default: '0};
    logic [DATA_W-1:0] dmem [MEM_BYTES] = '{default: '0};
    logic [DATA_W-1:0] pc_q   = '0;
    logic              halt_q = 1'b0;

    t_result pending_results [$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      src_burst   = 1'b0;
    bit      snk_burst   = 1'b0;

    // ---------------------------------------------------------------------
    // Directed tables. Starting from reset: pc 0, registers and memory zero.
    // ---------------------------------------------------------------------
    t_stim_row opening_rows [21] = '{
        // print right after reset: zero register, pc steps by three
        '{FN_PRINT,    8'h00, 8'h00, 1'b1, '{8'd3,   1'b1, 8'h00, 1'b0, ERR_OK}},
        '{FN_LDI,      8'h03, 8'hFF, 1'b1, '{8'd6,   1'b0, 8'h00, 1'b0, ERR_OK}},
        // host write to the top byte leaves pc alone
        '{FN_HOSTWR,   8'hFF, 8'hA5, 1'b1, '{8'd6,   1'b0, 8'h00, 1'b0, ERR_OK}},
        '{FN_LDM,      8'h02, 8'hFF, 1'b0, NO_EXP},
        '{FN_ADD,      8'h03, 8'h02, 1'b0, NO_EXP},   // 0xFF + 0xA5 wraps
        '{FN_SUB,      8'h01, 8'h03, 1'b0, NO_EXP},   // 0 - x wraps
        '{FN_PRINT,    8'h01, 8'h00, 1'b0, NO_EXP},
        '{FN_ST,       8'h00, 8'h03, 1'b0, NO_EXP},
        '{FN_LDM,      8'h00, 8'h00, 1'b0, NO_EXP},   // store forwarded to load when back to back
        // bad register operands: nothing changes, pc holds at 24
        '{FN_LDI,      8'h04, 8'h01, 1'b1, '{8'd24,  1'b0, 8'h00, 1'b0, ERR_BAD_REG}},
        '{FN_ST,       8'hFF, 8'hFF, 1'b1, '{8'd24,  1'b0, 8'h00, 1'b0, ERR_BAD_REG}},
        '{FN_ADD,      8'h00, 8'h04, 1'b1, '{8'd24,  1'b0, 8'h00, 1'b0, ERR_BAD_REG}},
        '{FN_JZ,       8'hFF, 8'h00, 1'b1, '{8'd24,  1'b0, 8'h00, 1'b0, ERR_BAD_REG}},
        // unknown functions
        '{FN_UNDEF_LO, 8'h00, 8'h00, 1'b1, '{8'd24,  1'b0, 8'h00, 1'b0, ERR_BAD_FUNC}},
        '{FN_UNDEF_HI, 8'hFF, 8'hFF, 1'b1, '{8'd24,  1'b0, 8'h00, 1'b0, ERR_BAD_FUNC}},
        // jmp ignores operand_a, so 0xFF there is no error
        '{FN_JMP,      8'hFF, 8'hFF, 1'b1, '{8'd255, 1'b0, 8'h00, 1'b0, ERR_OK}},
        '{FN_JZ,       8'h02, 8'h10, 1'b0, NO_EXP},   // not taken, pc wraps
        '{FN_JNZ,      8'h02, 8'h00, 1'b0, NO_EXP},   // taken
        '{FN_LDI,      8'h01, 8'h00, 1'b0, NO_EXP},
        '{FN_JZ,       8'h01, 8'hF0, 1'b0, NO_EXP},   // taken
        '{FN_JNZ,      8'h01, 8'h55, 1'b0, NO_EXP}    // not taken
    };

    // Stop can only come last: reset is never asserted again.
    t_stim_row closing_rows [4] = '{
        '{FN_STOP,     8'hFF, 8'hFF, 1'b0, NO_EXP},   // stop reads no register
        '{FN_PRINT,    8'h00, 8'h00, 1'b0, NO_EXP},   // ignored while halted
        '{FN_UNDEF_HI, 8'hFF, 8'hFF, 1'b0, NO_EXP},   // no error while halted
        '{FN_HOSTWR,   8'h00, 8'hFF, 1'b0, NO_EXP}    // host write still lands
    };

    // ---------------------------------------------------------------------
    // Model: executes one instruction on the local state, returns the result
    // ---------------------------------------------------------------------
    function automatic t_result execute_instr(input logic [FUNC_W-1:0] fn,
                                              input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
        t_result res;
        logic    need_a;
        logic    need_b;
        logic    advance;
        logic    taken;
        res     = NO_EXP;
        advance = 1'b1;
        taken   = 1'b0;
        need_a  = fn inside {FN_LDI, FN_LDM, FN_ADD, FN_SUB, FN_PRINT, FN_JZ, FN_JNZ};
        need_b  = fn inside {FN_ST, FN_ADD, FN_SUB};

        if (fn == FN_HOSTWR) begin
            dmem[a % MEM_BYTES] = b;
            advance = 1'b0;
        end else if (halt_q) begin
            advance = 1'b0;
        end else if (fn > FN_HOSTWR) begin
            res.error_code = ERR_BAD_FUNC;
            advance = 1'b0;
        end else if ((need_a && a >= REG_COUNT) || (need_b && b >= REG_COUNT)) begin
            res.error_code = ERR_BAD_REG;
            advance = 1'b0;
        end else begin
            case (fn)
                FN_LDI:   gpr[a] = b;
                FN_LDM:   gpr[a] = dmem[b % MEM_BYTES];
                FN_ST:    dmem[a % MEM_BYTES] = gpr[b];
                FN_ADD:   gpr[a] = gpr[a] + gpr[b];
                FN_SUB:   gpr[a] = gpr[a] - gpr[b];
                FN_PRINT: begin
                    res.print_valid = 1'b1;
                    res.print_value = gpr[a];
                end
                FN_JMP:   taken = 1'b1;
                FN_JZ:    taken = (gpr[a] == '0);
                FN_JNZ:   taken = (gpr[a] != '0);
                default: begin
                    halt_q  = 1'b1;
                    advance = 1'b0;
                end
            endcase
        end

        if (advance) begin
            pc_q = taken ? b : pc_q + 8'd3;
        end
        res.next_pc = pc_q;
        res.halted  = halt_q;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // ---------------------------------------------------------------------
    // Source side. Called at a rising edge; returns at the accepting edge.
    // valid stays high across back-to-back items (one NBA per step).
    // ---------------------------------------------------------------------
    task automatic send_instr(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] a,
                              input logic [DATA_W-1:0] b, input bit typed,
                              input t_result want);
        int unsigned gap;
        t_result     predicted;
        t_result     expected;
        if ($urandom_range(0, 39) == 0) begin
            src_burst = !src_burst;
        end
        gap = src_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= fn;
        in_ch.operand_a <= a;
        in_ch.operand_b <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        predicted = execute_instr(fn, a, b);
        expected  = typed ? want : predicted;
        pending_results = {pending_results, expected};
    endtask

    function automatic logic [DATA_W-1:0] pick_reg();
        // mostly legal register numbers, sometimes anything
        return ($urandom_range(0, 99) < 85) ? DATA_W'($urandom_range(0, REG_COUNT-1))
                                            : DATA_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [DATA_W-1:0] pick_addr();
        // a small hot region so loads see earlier stores
        return $urandom_range(0, 1) ? DATA_W'($urandom_range(0, 7))
                                    : DATA_W'($urandom_range(0, 255));
    endfunction

    // Random instruction. Outside the halted tail, stop is never drawn.
    task automatic send_random(input bit halted_phase);
        logic [FUNC_W-1:0] fn;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        int unsigned       pick;
        pick = $urandom_range(0, 99);
        a    = DATA_W'($urandom_range(0, 255));
        b    = DATA_W'($urandom_range(0, 255));
        if (halted_phase) begin
            fn = FUNC_W'($urandom_range(0, 15));
        end else if (pick < 4) begin
            fn = FUNC_W'($urandom_range(FN_UNDEF_LO, FN_UNDEF_HI));
        end else if (pick < 14) begin
            fn = FN_HOSTWR;
        end else begin
            fn = FUNC_W'($urandom_range(FN_LDI, FN_JNZ));
        end
        case (fn)
            FN_LDI: begin
                a = pick_reg();
                if ($urandom_range(0, 3) == 0) begin
                    b = '0;    // zeros feed jz / jnz
                end
            end
            FN_LDM: begin
                a = pick_reg();
                b = pick_addr();
            end
            FN_ST: begin
                a = pick_addr();
                b = pick_reg();
            end
            FN_ADD, FN_SUB: begin
                a = pick_reg();
                b = pick_reg();
            end
            FN_PRINT, FN_JZ, FN_JNZ: a = pick_reg();
            FN_HOSTWR:               a = pick_addr();
            default: ;
        endcase
        send_instr(fn, a, b, 1'b0, NO_EXP);
    endtask

    // ---------------------------------------------------------------------
    // Sink side: random stalls, compare each accepted item with the oldest
    // expectation
    // ---------------------------------------------------------------------
    initial begin
        int unsigned stall;
        t_result     exp_res;
        out_ch.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                snk_burst = !snk_burst;
            end
            stall = snk_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);

            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, next_pc %0h",
                                          out_ch.next_pc));
            end else begin
                exp_res = pending_results.pop_front();
                if (out_ch.next_pc !== exp_res.next_pc) begin
                    report_mismatch($sformatf("next_pc got %0h want %0h",
                                              out_ch.next_pc, exp_res.next_pc));
                end
                if (out_ch.print_valid !== exp_res.print_valid) begin
                    report_mismatch($sformatf("print_valid got %0b want %0b",
                                              out_ch.print_valid, exp_res.print_valid));
                end
                if (out_ch.print_value !== exp_res.print_value) begin
                    report_mismatch($sformatf("print_value got %0h want %0h",
                                              out_ch.print_value, exp_res.print_value));
                end
                if (out_ch.halted !== exp_res.halted) begin
                    report_mismatch($sformatf("halted got %0b want %0b",
                                              out_ch.halted, exp_res.halted));
                end
                if (out_ch.error_code !== exp_res.error_code) begin
                    report_mismatch($sformatf("error_code got %0d want %0d",
                                              out_ch.error_code, exp_res.error_code));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= WATCHDOG_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.func      = FN_LDI;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (opening_rows[i]) begin
            send_instr(opening_rows[i].fn, opening_rows[i].a, opening_rows[i].b,
                       opening_rows[i].typed, opening_rows[i].want);
        end
        repeat (RANDOM_ITEMS) send_random(1'b0);

        // halted tail: stop, then everything but host writes is ignored
        foreach (closing_rows[i]) begin
            send_instr(closing_rows[i].fn, closing_rows[i].a, closing_rows[i].b,
                       closing_rows[i].typed, closing_rows[i].want);
        end
        repeat (HALTED_ITEMS) send_random(1'b1);
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/mcpu_eu_pkg.sv
design/mcpu_eu_if.sv
design/mcpu_eu_rf.sv
design/mcpu_eu_dmem.sv
design/mini_cpu_execute_unit_core.sv
sim/testbench.sv
